/* rtl/core/thsr_pkg.sv */
// Shared constants, codes and slot record types of the statistics history ring.
package thsr_pkg;

   // Ring geometry
   localparam int HISTORY_DEPTH = 64;
   localparam int PTR_W         = $clog2(HISTORY_DEPTH);
   localparam int AGE_W         = 6;
   localparam int SLOT_MATH_W   = ((PTR_W > AGE_W) ? PTR_W : AGE_W) + 1;
   localparam int CHANNELS      = 4;
   localparam int CHAN_SEL_W    = 2;

   // Field widths
   localparam int ACT_W  = 2;
   localparam int SMP_W  = 16;
   localparam int HLT_W  = 32;
   localparam int VAL_W  = 33;
   localparam int SUM_W  = 49;
   localparam int CNT_W  = 16;
   localparam int SEQ_W  = 32;
   localparam int TICK_W = 16;

   // Packed stream widths, padded to whole bytes
   localparam int REQ_FIELDS_W = 2 * SMP_W + 1 + HLT_W + AGE_W + CHAN_SEL_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 3 * VAL_W + SUM_W + CNT_W + SEQ_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   // Item kinds carried on tuser
   localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TICK   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

   // Channel codes
   localparam logic [CHAN_SEL_W-1:0] CH_TEMP   = 2'd0;
   localparam logic [CHAN_SEL_W-1:0] CH_DRIVE  = 2'd1;
   localparam logic [CHAN_SEL_W-1:0] CH_HEATER = 2'd2;
   localparam logic [CHAN_SEL_W-1:0] CH_HEALTH = 2'd3;

   localparam logic [CNT_W-1:0]  COUNT_MAX       = 16'hFFFF;
   localparam logic [TICK_W-1:0] SLOT_TIME_RESET = 16'd1000;

   // Statistics of one channel within one slot
   typedef struct packed {
      logic signed [SUM_W-1:0] v_sum;
      logic signed [VAL_W-1:0] v_max;
      logic signed [VAL_W-1:0] v_min;
      logic signed [VAL_W-1:0] v_last;
   } chan_stats_type;

   // One ring slot as held in the slot memory
   typedef struct packed {
      chan_stats_type [CHANNELS-1:0] ch;
      logic [SEQ_W-1:0]              seq;
      logic [CNT_W-1:0]              count;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // Sample values of one item
   typedef struct packed {
      logic [HLT_W-1:0]        health_time;
      logic                    heater_on;
      logic signed [SMP_W-1:0] drive_output;
      logic signed [SMP_W-1:0] temperature;
   } sample_type;

endpackage

/* rtl/core/timed_statistics_history_ring.sv */
// Top level of the timed statistics history ring.
//
// Items arrive on the req_ channel: tuser gives the kind (sample, tick,
// read) and tdata the sample values, slot age and channel. A sample updates
// the current slot, a tick counts one millisecond and advances the ring
// after slot_time ticks, a read returns one channel of one slot on rsp_.
// slot_time is written on the csr_ channel, which is always ready.
// One item is accepted per cycle. Samples and reads fetch the slot row from
// memory (64 slots, one row each) at acceptance; a sample, or a tick that
// opens a slot, writes the row back in the next cycle, and a write-back
// register forwards it to a following item of the same slot. A read moves
// from the update stage into an output register that drives rsp_tvalid;
// while it waits there, samples and ticks keep flowing, and the next read
// stops in the update stage and holds req_tready low until rsp_tready frees
// the register. Reset empties every slot at once through per-slot valid bits,
// clears pointer, tick and sequence counters and loads slot_time with 1000;
// there is no clearing pass.
module timed_statistics_history_ring (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: temperature, drive_output, heater_on, health_time, slot_age, channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [thsr_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: action
   input  logic [thsr_pkg::ACT_W-1:0]      req_tuser,
   // rsp_tdata: value_last, value_min, value_max, value_sum, sample_count,
   //            slot_sequence, slot_empty
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [thsr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [thsr_pkg::TICK_W-1:0]     csr_data
);

   // Unpacked request fields
   thsr_pkg::sample_type              req_sample;
   logic [thsr_pkg::AGE_W-1:0]        req_age;
   logic [thsr_pkg::CHAN_SEL_W-1:0]   req_channel;
   logic                              accept;

   // Control state
   logic [thsr_pkg::TICK_W-1:0]       slot_time_ff, slot_time_in;
   logic [thsr_pkg::TICK_W-1:0]       tick_ff, tick_in;
   logic [thsr_pkg::PTR_W-1:0]        ptr_ff, ptr_in;
   logic [thsr_pkg::SEQ_W-1:0]        seq_ff, seq_in;
   logic [thsr_pkg::HISTORY_DEPTH-1:0] slot_valid_ff, slot_valid_in;

   // Tick and address arithmetic
   logic [thsr_pkg::TICK_W-1:0]       tick_inc;
   logic                              advance;
   logic [thsr_pkg::PTR_W-1:0]        ptr_step;
   logic [thsr_pkg::SLOT_MATH_W-1:0]  age_mod;
   logic [thsr_pkg::SLOT_MATH_W-1:0]  slot_diff;
   logic [thsr_pkg::PTR_W-1:0]        read_slot;

   // Update stage
   logic                              s1_valid_ff, s1_valid_in;
   logic [thsr_pkg::ACT_W-1:0]        s1_op_ff;
   logic [thsr_pkg::PTR_W-1:0]        s1_addr_ff;
   logic [thsr_pkg::SEQ_W-1:0]        s1_seq_ff;
   logic [thsr_pkg::CHAN_SEL_W-1:0]   s1_channel_ff;
   thsr_pkg::sample_type              s1_sample_ff;
   logic                              s1_load;
   logic                              stall;

   // Memory ports and write-back forwarding
   logic                              rd_en;
   logic [thsr_pkg::PTR_W-1:0]        rd_addr;
   logic [thsr_pkg::ENTRY_W-1:0]      rd_data;
   logic                              wr_en;
   thsr_pkg::slot_entry_type          wr_entry;
   logic                              wb_valid_ff, wb_valid_in;
   logic [thsr_pkg::PTR_W-1:0]        wb_addr_ff;
   thsr_pkg::slot_entry_type          wb_data_ff;
   thsr_pkg::slot_entry_type          cur_entry;
   thsr_pkg::slot_entry_type          upd_entry;
   thsr_pkg::slot_entry_type          tick_entry;
   logic                              upd_take;

   // Result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [thsr_pkg::RSP_DATA_W-1:0]   rsp_data_ff;
   logic                              rsp_load;
   thsr_pkg::chan_stats_type          sel_stats;
   logic                              sel_empty;

   // Unpack the request
   assign req_sample.temperature  = req_tdata[15:0];
   assign req_sample.drive_output = req_tdata[31:16];
   assign req_sample.heater_on    = req_tdata[32];
   assign req_sample.health_time  = req_tdata[64:33];
   assign req_age                 = req_tdata[70:65];
   assign req_channel             = req_tdata[72:71];

   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Hold the input while a read waits on a full result register
   assign stall      = s1_valid_ff && (s1_op_ff == thsr_pkg::ACT_READ) &&
                       rsp_valid_ff && !rsp_tready;
   assign req_tready = !stall;

   // Tick counting and ring advance
   assign tick_inc = tick_ff + 1'b1;
   assign advance  = (tick_inc >= slot_time_ff) || (tick_inc == '0);
   assign ptr_step = (ptr_ff == thsr_pkg::PTR_W'(thsr_pkg::HISTORY_DEPTH - 1)) ?
                     '0 : ptr_ff + 1'b1;

   // Slot addressed by age, counted back around the ring
   assign age_mod   = thsr_pkg::SLOT_MATH_W'(req_age % thsr_pkg::HISTORY_DEPTH);
   assign slot_diff = thsr_pkg::SLOT_MATH_W'(ptr_ff) - age_mod;
   assign read_slot = slot_diff[thsr_pkg::SLOT_MATH_W-1] ?
                      thsr_pkg::PTR_W'(slot_diff + thsr_pkg::SLOT_MATH_W'(thsr_pkg::HISTORY_DEPTH)) :
                      thsr_pkg::PTR_W'(slot_diff);

   // Issue the memory read at acceptance
   assign rd_en   = accept && ((req_tuser == thsr_pkg::ACT_SAMPLE) ||
                               (req_tuser == thsr_pkg::ACT_READ));
   assign rd_addr = (req_tuser == thsr_pkg::ACT_READ) ? read_slot : ptr_ff;

   // Items that go on to the update stage
   always_comb begin
      case (req_tuser)
         thsr_pkg::ACT_SAMPLE: s1_load = accept;
         thsr_pkg::ACT_TICK:   s1_load = accept && advance;
         thsr_pkg::ACT_READ:   s1_load = accept;
         default:              s1_load = 1'b0;
      endcase
   end

   // Advance pointer, tick and sequence counters; take csr writes
   always_comb begin
      tick_in      = tick_ff;
      ptr_in       = ptr_ff;
      seq_in       = seq_ff;
      slot_time_in = csr_valid ? csr_data : slot_time_ff;
      if (accept && (req_tuser == thsr_pkg::ACT_TICK)) begin
         if (advance) begin
            tick_in = '0;
            ptr_in  = ptr_step;
            seq_in  = seq_ff + 1'b1;
         end else begin
            tick_in = tick_inc;
         end
      end
   end

   assign s1_valid_in = stall ? s1_valid_ff : s1_load;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_time_ff  <= thsr_pkg::SLOT_TIME_RESET;
         tick_ff       <= '0;
         ptr_ff        <= '0;
         seq_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         wb_valid_ff   <= 1'b0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_time_ff  <= slot_time_in;
         tick_ff       <= tick_in;
         ptr_ff        <= ptr_in;
         seq_ff        <= seq_in;
         s1_valid_ff   <= s1_valid_in;
         wb_valid_ff   <= wb_valid_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Update stage payload
   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_op_ff      <= req_tuser;
         s1_seq_ff     <= seq_ff;
         s1_channel_ff <= req_channel;
         s1_sample_ff  <= req_sample;
         case (req_tuser)
            thsr_pkg::ACT_TICK: s1_addr_ff <= ptr_step;
            thsr_pkg::ACT_READ: s1_addr_ff <= read_slot;
            default:            s1_addr_ff <= ptr_ff;
         endcase
      end
   end

   thsr_ram #(
      .WIDTH (thsr_pkg::ENTRY_W),
      .DEPTH (thsr_pkg::HISTORY_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Current slot contents: forwarded row, stored row, or an empty slot
   always_comb begin
      if (wb_valid_ff && (wb_addr_ff == s1_addr_ff)) begin
         cur_entry = wb_data_ff;
      end else if (slot_valid_ff[s1_addr_ff]) begin
         cur_entry = rd_data;
      end else begin
         cur_entry = '0;
      end
   end

   thsr_slot_update u_update (
      .old_entry (cur_entry),
      .sample    (s1_sample_ff),
      .new_entry (upd_entry),
      .take      (upd_take)
   );

   // Fresh slot opened by a tick
   always_comb begin
      tick_entry     = '0;
      tick_entry.seq = s1_seq_ff;
   end

   // Write back the row
   always_comb begin
      case (s1_op_ff)
         thsr_pkg::ACT_SAMPLE: wr_en = s1_valid_ff && upd_take;
         thsr_pkg::ACT_TICK:   wr_en = s1_valid_ff;
         default:              wr_en = 1'b0;
      endcase
   end

   assign wr_entry = (s1_op_ff == thsr_pkg::ACT_TICK) ? tick_entry : upd_entry;

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (wr_en) begin
         slot_valid_in[s1_addr_ff] = 1'b1;
      end
   end

   assign wb_valid_in = wb_valid_ff || wr_en;

   // Keep the last written row for forwarding
   always_ff @(posedge clock) begin
      if (wr_en) begin
         wb_addr_ff <= s1_addr_ff;
         wb_data_ff <= wr_entry;
      end
   end

   // Select the read channel; an empty slot reports zero values
   assign sel_empty = (cur_entry.count == '0);
   assign sel_stats = sel_empty ? '0 : cur_entry.ch[s1_channel_ff];

   assign rsp_load     = s1_valid_ff && (s1_op_ff == thsr_pkg::ACT_READ) &&
                         (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {{thsr_pkg::RSP_PAD_W{1'b0}}, sel_empty, cur_entry.seq,
                         cur_entry.count, sel_stats.v_sum, sel_stats.v_max,
                         sel_stats.v_min, sel_stats.v_last};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A stalled read stays in the update stage untouched
   assert property (@(posedge clock) disable iff (reset)
      stall |=> s1_valid_ff && (s1_op_ff == thsr_pkg::ACT_READ) && $stable(s1_addr_ff))
      else $error("stalled read left the update stage");

   // A result only appears behind a read in the update stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && (s1_op_ff == thsr_pkg::ACT_READ)))
      else $error("result without a read");

   // The ring only moves on an accepted tick, and the sequence moves with it
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (ptr_ff != $past(ptr_ff))) |->
         ($past(accept && (req_tuser == thsr_pkg::ACT_TICK)) &&
          (seq_ff == $past(seq_ff) + 1'b1)))
      else $error("ring advanced without a tick");

   // No memory write while a read holds the update stage
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_op_ff == thsr_pkg::ACT_READ)) |-> !wr_en)
      else $error("write issued by a read");

endmodule

/* rtl/core/thsr_ram.sv */
// Generic single-write, single-read memory with registered read data.
module thsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/thsr_slot_update.sv */
// Merge of one sample item into the statistics of a slot.
module thsr_slot_update (
   input  thsr_pkg::slot_entry_type old_entry,
   input  thsr_pkg::sample_type     sample,
   output thsr_pkg::slot_entry_type new_entry,
   output logic                     take
);

   logic signed [thsr_pkg::VAL_W-1:0] val [thsr_pkg::CHANNELS];
   logic                              first;

   // Widen each sample to the common value width
   always_comb begin
      val[thsr_pkg::CH_TEMP]   = {{(thsr_pkg::VAL_W - thsr_pkg::SMP_W){sample.temperature[thsr_pkg::SMP_W-1]}},
                                  sample.temperature};
      val[thsr_pkg::CH_DRIVE]  = {{(thsr_pkg::VAL_W - thsr_pkg::SMP_W){sample.drive_output[thsr_pkg::SMP_W-1]}},
                                  sample.drive_output};
      val[thsr_pkg::CH_HEATER] = {{(thsr_pkg::VAL_W - 1){1'b0}}, sample.heater_on};
      val[thsr_pkg::CH_HEALTH] = {{(thsr_pkg::VAL_W - thsr_pkg::HLT_W){1'b0}}, sample.health_time};
   end

   // Drop the sample once the slot count has saturated
   assign take  = (old_entry.count != thsr_pkg::COUNT_MAX);
   assign first = (old_entry.count == '0);

   // Update last, minimum, maximum and sum of every channel
   always_comb begin
      new_entry       = old_entry;
      new_entry.count = old_entry.count + 1'b1;
      for (int c = 0; c < thsr_pkg::CHANNELS; c++) begin
         new_entry.ch[c].v_last = val[c];
         if (first) begin
            new_entry.ch[c].v_min = val[c];
            new_entry.ch[c].v_max = val[c];
            new_entry.ch[c].v_sum = {{(thsr_pkg::SUM_W - thsr_pkg::VAL_W){val[c][thsr_pkg::VAL_W-1]}},
                                     val[c]};
         end else begin
            if (val[c] < old_entry.ch[c].v_min) begin
               new_entry.ch[c].v_min = val[c];
            end
            if (val[c] > old_entry.ch[c].v_max) begin
               new_entry.ch[c].v_max = val[c];
            end
            new_entry.ch[c].v_sum = old_entry.ch[c].v_sum +
               {{(thsr_pkg::SUM_W - thsr_pkg::VAL_W){val[c][thsr_pkg::VAL_W-1]}}, val[c]};
         end
      end
   end

endmodule

/* dv/thsr_checker.sv */
`timescale 1ns / 1ps
// Checker for the statistics history ring: watches the channels, predicts reads, compares.
module thsr_checker
   import thsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [ACT_W-1:0]      req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [TICK_W-1:0]     csr_data,
   output int                    fail_count,
   output int                    pending
);

   localparam int SAMPLE_W = $bits(sample_type);

   // One read result, laid out as it sits in rsp_tdata (lowest field last)
   typedef struct packed {
      logic                    slot_empty;
      logic [SEQ_W-1:0]        slot_sequence;
      logic [CNT_W-1:0]        sample_count;
      logic signed [SUM_W-1:0] value_sum;
      logic signed [VAL_W-1:0] value_max;
      logic signed [VAL_W-1:0] value_min;
      logic signed [VAL_W-1:0] value_last;
   } read_result_type;

   // Shadow copy of the ring
   logic [TICK_W-1:0]       slot_period;
   logic [TICK_W-1:0]       tick_cnt;
   logic [PTR_W-1:0]        cur_slot;
   logic [SEQ_W-1:0]        seq_next;
   logic signed [VAL_W-1:0] last_v [HISTORY_DEPTH][CHANNELS];
   logic signed [VAL_W-1:0] min_v  [HISTORY_DEPTH][CHANNELS];
   logic signed [VAL_W-1:0] max_v  [HISTORY_DEPTH][CHANNELS];
   logic signed [SUM_W-1:0] sum_v  [HISTORY_DEPTH][CHANNELS];
   logic [CNT_W-1:0]        slot_count [HISTORY_DEPTH];
   logic [SEQ_W-1:0]        slot_seq   [HISTORY_DEPTH];

   read_result_type         read_results [$];

   // Return the ring to its state after reset
   task automatic clear_history();
      slot_period = SLOT_TIME_RESET;
      tick_cnt    = '0;
      cur_slot    = '0;
      seq_next    = '0;
      for (int s = 0; s < HISTORY_DEPTH; s++) begin
         slot_count[s] = '0;
         slot_seq[s]   = '0;
         for (int c = 0; c < CHANNELS; c++) begin
            last_v[s][c] = '0;
            min_v[s][c]  = '0;
            max_v[s][c]  = '0;
            sum_v[s][c]  = '0;
         end
      end
   endtask

   // Fold one sample into the current slot, drop it once the count is full
   task automatic take_sample(input sample_type smp);
      logic signed [VAL_W-1:0] v [CHANNELS];
      logic signed [SUM_W-1:0] wide;
      logic [CNT_W-1:0]        n;
      n = slot_count[cur_slot];
      if (n == COUNT_MAX) return;
      v[CH_TEMP]   = {{(VAL_W-SMP_W){smp.temperature[SMP_W-1]}}, smp.temperature};
      v[CH_DRIVE]  = {{(VAL_W-SMP_W){smp.drive_output[SMP_W-1]}}, smp.drive_output};
      v[CH_HEATER] = {{(VAL_W-1){1'b0}}, smp.heater_on};
      v[CH_HEALTH] = {1'b0, smp.health_time};
      for (int c = 0; c < CHANNELS; c++) begin
         wide = {{(SUM_W-VAL_W){v[c][VAL_W-1]}}, v[c]};
         last_v[cur_slot][c] = v[c];
         if (n == '0) begin
            min_v[cur_slot][c] = v[c];
            max_v[cur_slot][c] = v[c];
            sum_v[cur_slot][c] = wide;
         end else begin
            if (v[c] < min_v[cur_slot][c]) min_v[cur_slot][c] = v[c];
            if (v[c] > max_v[cur_slot][c]) max_v[cur_slot][c] = v[c];
            sum_v[cur_slot][c] = sum_v[cur_slot][c] + wide;
         end
      end
      slot_count[cur_slot] = n + 1'b1;
   endtask

   // Count one millisecond; open and stamp the next slot when the time is up
   task automatic take_tick();
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= slot_period || tick_cnt == '0) begin
         tick_cnt             = '0;
         cur_slot             = cur_slot + 1'b1;
         slot_count[cur_slot] = '0;
         slot_seq[cur_slot]   = seq_next;
         seq_next             = seq_next + 1'b1;
      end
   endtask

   // Work out what a read of one channel of one slot returns
   function automatic read_result_type predict_read(input logic [AGE_W-1:0] age,
                                                    input logic [CHAN_SEL_W-1:0] chan);
      read_result_type  r;
      logic [PTR_W-1:0] s;
      s = cur_slot - PTR_W'(age);
      r = '0;
      r.sample_count  = slot_count[s];
      r.slot_sequence = slot_seq[s];
      r.slot_empty    = (slot_count[s] == '0);
      if (!r.slot_empty) begin
         r.value_last = last_v[s][chan];
         r.value_min  = min_v[s][chan];
         r.value_max  = max_v[s][chan];
         r.value_sum  = sum_v[s][chan];
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
         fail_count++;
      end
   endtask

   // Track every handshake on the rising edge
   always @(posedge clock) begin
      read_result_type want;
      read_result_type seen;
      if (reset) begin
         clear_history();
         read_results.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) slot_period = csr_data;

         // Compare a delivered result with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[RSP_FIELDS_W-1:0];
            if (read_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, seen);
               fail_count++;
            end else begin
               want = read_results.pop_front();
               check_field("value_last", 64'(want.value_last), 64'(seen.value_last));
               check_field("value_min", 64'(want.value_min), 64'(seen.value_min));
               check_field("value_max", 64'(want.value_max), 64'(seen.value_max));
               check_field("value_sum", 64'(want.value_sum), 64'(seen.value_sum));
               check_field("sample_count", 64'(want.sample_count),
                           64'(seen.sample_count));
               check_field("slot_sequence", 64'(want.slot_sequence),
                           64'(seen.slot_sequence));
               check_field("slot_empty", 64'(want.slot_empty), 64'(seen.slot_empty));
            end
         end

         // Advance the shadow ring with each accepted item
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               ACT_SAMPLE: take_sample(req_tdata[SAMPLE_W-1:0]);
               ACT_TICK:   take_tick();
               ACT_READ:   read_results.push_back(
                              predict_read(req_tdata[SAMPLE_W +: AGE_W],
                                           req_tdata[SAMPLE_W+AGE_W +: CHAN_SEL_W]));
               default: ;
            endcase
         end
      end
      pending = read_results.size();
   end

endmodule

/* dv/tb_timed_statistics_history_ring.sv */
`timescale 1ns / 1ps
// Testbench top for the statistics history ring: clock, reset, stimulus and verdict.
module tb_timed_statistics_history_ring;
   import thsr_pkg::*;

   localparam logic [ACT_W-1:0] ACT_UNUSED   = 2'd3;
   localparam int               DRAIN_CYCLES = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [ACT_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [TICK_W-1:0]     csr_data;
   int                    fail_count;
   int                    pending;
   bit                    req_steady;
   bit                    rsp_steady;

   timed_statistics_history_ring dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   thsr_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #15_000_000;
      $display("timed_statistics_history_ring test failed");
      $finish;
   end

   // Idle lengths: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic sample_type mk_sample(input logic [SMP_W-1:0] temp,
                                            input logic [SMP_W-1:0] drive,
                                            input logic heat,
                                            input logic [HLT_W-1:0] health);
      sample_type smp;
      smp.temperature  = temp;
      smp.drive_output = drive;
      smp.heater_on    = heat;
      smp.health_time  = health;
      return smp;
   endfunction

   // Random sample values, leaning on the range limits a quarter of the time
   function automatic sample_type rand_sample();
      logic [SMP_W-1:0] t;
      logic [SMP_W-1:0] d;
      logic [HLT_W-1:0] h;
      case ($urandom_range(0, 7))
         0:       t = 16'h8000;
         1:       t = 16'h7FFF;
         default: t = SMP_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0:       d = 16'h8000;
         1:       d = 16'h7FFF;
         default: d = SMP_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0:       h = 32'h0000_0000;
         1:       h = 32'hFFFF_FFFF;
         default: h = $urandom;
      endcase
      return mk_sample(t, d, 1'($urandom_range(0, 1)), h);
   endfunction

   // Present one item and hold it until accepted
   task automatic send_item(input logic [ACT_W-1:0] act, input sample_type smp,
                            input logic [AGE_W-1:0] age, input logic [CHAN_SEL_W-1:0] chan);
      int gap;
      gap = req_steady ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= REQ_DATA_W'({chan, age, smp});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic read_slot(input logic [AGE_W-1:0] age, input logic [CHAN_SEL_W-1:0] chan);
      send_item(ACT_READ, rand_sample(), age, chan);
   endtask

   task automatic send_tick();
      send_item(ACT_TICK, rand_sample(), AGE_W'($urandom), CHAN_SEL_W'($urandom));
   endtask

   // Stop sending and wait until every read has been answered
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_slot_time(input logic [TICK_W-1:0] ticks);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= ticks;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random item; reads mostly look at recent slots
   task automatic rand_item();
      int r;
      logic [AGE_W-1:0] age;
      r   = $urandom_range(0, 99);
      age = ($urandom_range(0, 9) < 6) ? AGE_W'($urandom_range(0, 3)) : AGE_W'($urandom);
      if (r < 45)
         send_item(ACT_SAMPLE, rand_sample(), AGE_W'($urandom), CHAN_SEL_W'($urandom));
      else if (r < 72)
         send_tick();
      else if (r < 97)
         read_slot(age, CHAN_SEL_W'($urandom));
      else
         send_item(ACT_UNUSED, rand_sample(), age, CHAN_SEL_W'($urandom));
   endtask

   // Result side back-pressure
   initial begin
      int stall;
      int run;
      rsp_tready = 1'b0;
      forever begin
         if (rsp_steady) begin
            @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            stall = pick_gap();
            run   = $urandom_range(1, 12);
            repeat (stall) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
            repeat (run) begin
               @(negedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Stimulus and verdict
   initial begin
      logic [TICK_W-1:0] settings [6];
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_SAMPLE;
      csr_valid  = 1'b0;
      csr_data   = '0;
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      reset      = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Read an empty slot straight after reset
      read_slot(0, CH_TEMP);
      // Extremes of every sample field
      send_item(ACT_SAMPLE, mk_sample(16'h8000, 16'h7FFF, 1'b1, 32'hFFFF_FFFF), 0, CH_TEMP);
      send_item(ACT_SAMPLE, mk_sample(16'h7FFF, 16'h8000, 1'b0, 32'h0), 6'h3F, CH_HEALTH);
      read_slot(0, CH_TEMP);
      read_slot(0, CH_DRIVE);
      read_slot(0, CH_HEATER);
      read_slot(0, CH_HEALTH);
      // Unused action code must leave the ring alone
      send_item(ACT_UNUSED, mk_sample(16'h1, 16'h1, 1'b1, 32'h1), 0, CH_TEMP);
      read_slot(0, CH_DRIVE);

      // Zero slot time: every tick opens a new slot
      write_slot_time(16'd0);
      send_tick();
      send_item(ACT_SAMPLE, mk_sample(16'd5, 16'hFFFB, 1'b1, 32'd7), 0, CH_TEMP);
      send_tick();
      read_slot(1, CH_HEATER);
      read_slot(2, CH_TEMP);
      read_slot(6'h3F, CH_HEALTH);
      read_slot(0, CH_DRIVE);

      // Lower the slot time beneath the running tick count
      write_slot_time(16'hFFFF);
      repeat (5) send_tick();
      write_slot_time(16'd2);
      send_tick();
      read_slot(0, CH_HEALTH);
      read_slot(1, CH_TEMP);

      // Random phases over a spread of slot times
      settings[0] = 16'd1;
      settings[1] = 16'd0;
      settings[2] = 16'd3;
      settings[3] = 16'd7;
      settings[4] = 16'hFFFF;
      settings[5] = TICK_W'($urandom_range(2, 40));
      foreach (settings[p]) begin
         write_slot_time(settings[p]);
         for (int i = 0; i < 300; i++) begin
            if (i % 50 == 0) begin
               req_steady = ($urandom_range(0, 3) == 0);
               rsp_steady = ($urandom_range(0, 3) == 0);
            end
            // Hold off until every answer is in, once per phase
            if (i == 150) drain();
            rand_item();
         end
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;

      drain();
      if (fail_count == 0 && pending == 0)
         $display("timed_statistics_history_ring test passed");
      else
         $display("timed_statistics_history_ring test failed");
      $finish;
   end

endmodule
